@@ rtl/assert_macros.svh @@
// Assertion macros for the histogram top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tbah_pkg.sv @@
// Package: sizes, codes and types of the type-by-area histogram.
`timescale 1ns / 1ps
`default_nettype none

package tbah_pkg;

    localparam int NUM_TYPES   = 14;
    localparam int NUM_EDGES   = 6;
    localparam int NUM_BUCKETS = NUM_EDGES + 1;
    localparam int NUM_CELLS   = NUM_TYPES * NUM_BUCKETS;
    localparam int NUM_REGS    = 6;

    localparam int VALUE_W     = 32;
    localparam int TYPE_W      = 5;
    localparam int COL_W       = 3;
    localparam int MODE_W      = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_IDX_W   = 3;

    localparam int ROW_W       = $clog2(NUM_TYPES);
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int ADDR_W      = $clog2(NUM_CELLS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes on the mode field
    localparam logic [MODE_W-1:0] MODE_RECORD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ_CELL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_TOTAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

    localparam logic [VALUE_W-1:0] EDGE_RESET [NUM_REGS] = '{
        32'd1024, 32'd4800, 32'd38400, 32'd57600, 32'd120000, 32'd921600
    };

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_READ_CELL,
        OP_READ_TOTAL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } bk_status_t;

    typedef enum logic {
        B_IDLE,
        B_ACCESS
    } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/type_by_area_histogram_unit.sv @@
// Top level of the type-by-area event histogram.
//
//  channel   direction  handshake              contents
//  cfg       in         cfg_valid/cfg_ready    cfg_index (edge register), cfg_data
//  s_        in         s_tvalid/s_tready      mode, event_type, event_size, read_bucket
//  m_        out        m_tvalid/m_tready      read_value
//
// The front end takes an item each cycle while its stage register can drain into
// a four-entry request queue; items are classified on their way into that register.
// The back end handles one request at a time (counter RAM read on the pop, then
// update or result load) and takes no new request until it is done with the last.
// Reset clears the edges to their defaults and the per-cell written flags, so all
// counters read as zero straight after reset; no clearing pass is run.
// A stalled result holds the back end; the queue keeps the front end taking items until it fills.
`timescale 1ns / 1ps
`default_nettype none

module type_by_area_histogram_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tbah_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tbah_pkg::VALUE_W-1:0]      cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] mode, [6:2] event_type, [38:7] event_size, [41:39] read_bucket, rest zero
    input  wire logic [tbah_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] read_value
    output logic [tbah_pkg::M_TDATA_W-1:0]         m_tdata
);
    import tbah_pkg::*;

    logic       q_push;
    logic       q_pop;
    q_entry_t   q_wr_entry;
    q_entry_t   q_rd_entry;
    q_status_t  q_status;
    bk_status_t bk_status;

    tbah_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_push     (q_push),
        .q_wr_entry (q_wr_entry),
        .q_status   (q_status)
    );

    tbah_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .status   (q_status)
    );

    tbah_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_entry (q_rd_entry),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .bk_status  (bk_status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // queue bookkeeping and back-end sequencing checks
`include "assert_macros.svh"
    `ASSERT_IMP(a_no_overflow, q_push, !q_status.full, "request queue overflow")
    `ASSERT_IMP(a_no_underflow, q_pop, !q_status.empty, "request queue underflow")
    `ASSERT_IMP(a_pop_when_idle, q_pop, !bk_status.busy, "pop while back end busy")
    `ASSERT_NXT(a_pop_starts_access, q_pop, bk_status.busy, "pop did not start an access")

endmodule

`default_nettype wire

@@ rtl/tbah_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tbah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 98
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tbah_front.sv @@
// Front end: edge registers, item intake, row and bucket classification.
`timescale 1ns / 1ps
`default_nettype none

module tbah_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tbah_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tbah_pkg::VALUE_W-1:0]      cfg_data,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tbah_pkg::S_TDATA_W-1:0]    s_tdata,
    // to queue
    output logic                                   q_push,
    output tbah_pkg::q_entry_t                     q_wr_entry,
    input  wire tbah_pkg::q_status_t               q_status
);
    import tbah_pkg::*;

    logic [VALUE_W-1:0] edge_reg  [NUM_REGS];
    logic [VALUE_W-1:0] edge_next [NUM_REGS];
    logic               stage_valid_reg;
    logic               stage_valid_next;
    q_entry_t           stage_reg;
    q_entry_t           stage_next;

    logic [MODE_W-1:0]  f_mode;
    logic [TYPE_W-1:0]  f_type;
    logic [VALUE_W-1:0] f_size;
    logic [COL_W-1:0]   f_col;
    logic [ROW_W-1:0]   row;
    logic [BKT_W-1:0]   bkt_rec;
    logic [BKT_W-1:0]   bkt_rd;
    logic               accept;

    // field unpacking, first field lowest
    assign f_mode = s_tdata[1:0];
    assign f_type = s_tdata[6:2];
    assign f_size = s_tdata[38:7];
    assign f_col  = s_tdata[41:39];

    assign cfg_ready = 1'b1;
    assign q_push     = stage_valid_reg && !q_status.full;
    assign q_wr_entry = stage_reg;
    assign s_tready   = !stage_valid_reg || q_push;
    assign accept     = s_tvalid && s_tready;

    // edge registers; writes beyond the list are dropped
    always_comb begin
        edge_next = edge_reg;
        if (cfg_valid && (int'(cfg_index) < NUM_REGS)) begin
            edge_next[cfg_index] = cfg_data;
        end
    end

    // row clamp to the other row, read column clamp to the over bucket
    always_comb begin
        if (int'(f_type) >= NUM_TYPES - 1) begin
            row = ROW_W'(NUM_TYPES - 1);
        end else begin
            row = ROW_W'(f_type);
        end
        if (int'(f_col) > NUM_EDGES) begin
            bkt_rd = BKT_W'(NUM_EDGES);
        end else begin
            bkt_rd = BKT_W'(f_col);
        end
    end

    // first edge not exceeded wins; none gives the over bucket
    always_comb begin
        bkt_rec = BKT_W'(NUM_EDGES);
        for (int i = NUM_EDGES - 1; i >= 0; i--) begin
            if (f_size <= edge_reg[i]) begin
                bkt_rec = BKT_W'(i);
            end
        end
    end

    // stage register: classified item waiting for queue space
    always_comb begin
        stage_next       = stage_reg;
        stage_valid_next = stage_valid_reg;
        if (q_push) begin
            stage_valid_next = 1'b0;
        end
        if (accept) begin
            stage_valid_next = (f_mode != MODE_UNUSED);
            case (f_mode)
                MODE_RECORD: begin
                    stage_next.op   = OP_RECORD;
                    stage_next.addr = ADDR_W'(row) * ADDR_W'(NUM_BUCKETS) + ADDR_W'(bkt_rec);
                end
                MODE_READ_CELL: begin
                    stage_next.op   = OP_READ_CELL;
                    stage_next.addr = ADDR_W'(row) * ADDR_W'(NUM_BUCKETS) + ADDR_W'(bkt_rd);
                end
                default: begin
                    stage_next.op   = OP_READ_TOTAL;
                    stage_next.addr = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg        <= EDGE_RESET;
            stage_valid_reg <= 1'b0;
        end else begin
            edge_reg        <= edge_next;
            stage_valid_reg <= stage_valid_next;
        end
        stage_reg <= stage_next;
    end

endmodule

`default_nettype wire

@@ rtl/tbah_queue.sv @@
// Short FIFO of classified requests between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module tbah_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire tbah_pkg::q_entry_t  wr_entry,
    input  wire logic                pop,
    output tbah_pkg::q_entry_t       rd_entry,
    output tbah_pkg::q_status_t      status
);
    import tbah_pkg::*;

    q_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign rd_entry     = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tbah_back.sv @@
// Back end: counter read-modify-write, total counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module tbah_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // from queue
    input  wire tbah_pkg::q_entry_t              q_rd_entry,
    input  wire tbah_pkg::q_status_t             q_status,
    output logic                                 q_pop,
    output tbah_pkg::bk_status_t                 bk_status,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tbah_pkg::M_TDATA_W-1:0]       m_tdata
);
    import tbah_pkg::*;

    bk_state_t          state_reg, state_next;
    q_entry_t           entry_reg, entry_next;
    logic [NUM_CELLS-1:0] written_reg, written_next;
    logic [VALUE_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;

    logic               ram_wr_en;
    logic [VALUE_W-1:0] ram_wr_data;
    logic [VALUE_W-1:0] ram_rd_data;
    logic [VALUE_W-1:0] cell_value;
    logic               out_free;

    tbah_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (entry_reg.addr),
        .wr_data (ram_wr_data),
        .rd_en   (q_pop),
        .rd_addr (q_rd_entry.addr),
        .rd_data (ram_rd_data)
    );

    // a cell never written since reset counts as zero
    assign cell_value = written_reg[entry_reg.addr] ? ram_rd_data : '0;
    assign out_free   = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign bk_status.busy = (state_reg == B_ACCESS);

    // request sequencer: fetch cell, then update it or hand out a result
    always_comb begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        written_next   = written_reg;
        total_next     = total_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_data    = cell_value + 1'b1;
        case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    entry_next = q_rd_entry;
                    state_next = B_ACCESS;
                end
            end
            B_ACCESS: begin
                case (entry_reg.op)
                    OP_RECORD: begin
                        ram_wr_en                   = 1'b1;
                        written_next[entry_reg.addr] = 1'b1;
                        total_next                  = total_reg + 1'b1;
                        state_next                  = B_IDLE;
                    end
                    OP_READ_CELL: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            out_data_next  = cell_value;
                            state_next     = B_IDLE;
                        end
                    end
                    OP_READ_TOTAL: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            out_data_next  = total_reg;
                            state_next     = B_IDLE;
                        end
                    end
                    default: begin
                        state_next = B_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            written_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
        entry_reg    <= entry_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ tb/type_by_area_histogram_unit_tb.sv @@
// Self-checking testbench for the type-by-area histogram unit.
`timescale 1ns / 1ps

module type_by_area_histogram_unit_tb;

    import tbah_pkg::*;

    localparam int SETTLE_CYCLES  = 40;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int REPORT_LIMIT   = 10;

    // Edge register indexes; the top two indexes are unmapped
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_FOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_FIVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_SIX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [VALUE_W-1:0] SIZE_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [TYPE_W-1:0]  ev_type;
        logic [VALUE_W-1:0] ev_size;
        logic [COL_W-1:0]   col;
        bit                 drain_first;
    } event_item_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [VALUE_W-1:0]      cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;

    // Stimulus and expectation stores
    event_item_t             event_q[$];
    logic [VALUE_W-1:0]      read_value_q[$];
    logic                    s_took = 1'b0;

    // Mirror of the histogram state
    logic [VALUE_W-1:0]      bucket_limit [NUM_EDGES];
    logic [VALUE_W-1:0]      cell_count [NUM_TYPES][NUM_BUCKETS];
    logic [VALUE_W-1:0]      event_total;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int n_records      = 0;
    int n_cell_reads   = 0;
    int n_total_reads  = 0;
    int n_ignored      = 0;
    int n_checked      = 0;
    int n_cfg_writes   = 0;

    type_by_area_histogram_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Row select: high type codes fold into the other row
    function automatic int row_for(logic [TYPE_W-1:0] code);
        return (code >= NUM_TYPES - 1) ? NUM_TYPES - 1 : int'(code);
    endfunction

    // First bucket whose upper limit is not exceeded, edges tested in order
    function automatic int bucket_for(logic [VALUE_W-1:0] size);
        int b;
        b = 0;
        while (b < NUM_EDGES && size > bucket_limit[b])
            b++;
        return b;
    endfunction

    // Update the mirror for one accepted item and queue any read value
    task automatic histogram_step(logic [S_TDATA_W-1:0] word);
        logic [MODE_W-1:0]  mode;
        logic [TYPE_W-1:0]  code;
        logic [VALUE_W-1:0] size;
        logic [COL_W-1:0]   col;
        int                 row;
        int                 b;
        mode = word[1:0];
        code = word[6:2];
        size = word[38:7];
        col  = word[41:39];
        row  = row_for(code);
        case (mode)
            MODE_RECORD: begin
                b = bucket_for(size);
                cell_count[row][b] = cell_count[row][b] + 1'b1;
                event_total = event_total + 1'b1;
                n_records++;
            end
            MODE_READ_CELL: begin
                b = (col > NUM_EDGES) ? NUM_EDGES : int'(col);
                read_value_q.push_back(cell_count[row][b]);
                n_cell_reads++;
            end
            MODE_READ_TOTAL: begin
                read_value_q.push_back(event_total);
                n_total_reads++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic add_item(logic [MODE_W-1:0] mode, logic [TYPE_W-1:0] code,
                            logic [VALUE_W-1:0] size, logic [COL_W-1:0] col,
                            bit drain_first = 1'b0);
        event_item_t it;
        it.mode        = mode;
        it.ev_type     = code;
        it.ev_size     = size;
        it.col         = col;
        it.drain_first = drain_first;
        event_q.push_back(it);
    endtask

    // Sizes cluster around the current limits so every bucket gets hits
    function automatic logic [VALUE_W-1:0] pick_size();
        int k;
        k = int'($urandom_range(0, NUM_EDGES - 1));
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return bucket_limit[k];
            2:       return bucket_limit[k] + 1'b1;
            3:       return bucket_limit[k] - 1'b1;
            4:       return SIZE_MAX;
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // Mostly records and cell reads on a few busy rows; a pause for drain mid-way
    task automatic queue_random(int count);
        logic [MODE_W-1:0] mode;
        logic [TYPE_W-1:0] code;
        int                pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                mode = MODE_RECORD;
            else if (pick < 85)
                mode = MODE_READ_CELL;
            else if (pick < 95)
                mode = MODE_READ_TOTAL;
            else
                mode = MODE_UNUSED;
            if ($urandom_range(0, 3) == 0)
                code = TYPE_W'($urandom_range(0, 31));
            else
                code = TYPE_W'($urandom_range(10, 14));
            add_item(mode, code, pick_size(), COL_W'($urandom_range(0, 7)),
                     i == count / 2);
        end
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS)
            bucket_limit[idx] = value;
        n_cfg_writes++;
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until all items are sent and all read values returned, then let
    // trailing records finish inside the unit
    task automatic wait_drained();
        do @(posedge aclk);
        while (event_q.size() != 0 || s_tvalid || read_value_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Driver: new inputs at the falling edge
    always @(negedge aclk) begin
        event_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_took) begin
                if (event_q.size() != 0
                        && !(event_q[0].drain_first && read_value_q.size() != 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({nxt.col, nxt.ev_size, nxt.ev_type, nxt.mode});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge aclk) begin
        logic [VALUE_W-1:0] want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                histogram_step(s_tdata);
            if (m_tvalid && m_tready) begin
                if (read_value_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: unexpected result read_value=%h", m_tdata);
                end else begin
                    want = read_value_q.pop_front();
                    n_checked++;
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("ERROR: read_value expected %h got %h", want, m_tdata);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_EDGES; i++)
            bucket_limit[i] = EDGE_RESET[i];
        for (int r = 0; r < NUM_TYPES; r++)
            for (int b = 0; b < NUM_BUCKETS; b++)
                cell_count[r][b] = '0;
        event_total = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default limits, no idling: directed corner cases first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_item(MODE_READ_TOTAL, 5'd0, '0, 3'd0);
        add_item(MODE_READ_CELL, 5'd0, '0, 3'd0);
        add_item(MODE_RECORD, 5'd0, 32'd0, 3'd0);
        add_item(MODE_RECORD, 5'd0, 32'd1024, 3'd0);
        add_item(MODE_RECORD, 5'd0, 32'd1025, 3'd0);
        add_item(MODE_RECORD, 5'd12, 32'd921600, 3'd0);
        add_item(MODE_RECORD, 5'd13, 32'd921601, 3'd0);
        add_item(MODE_RECORD, 5'd31, SIZE_MAX, 3'd7);
        add_item(MODE_RECORD, 5'd20, 32'd38401, 3'd0);
        add_item(MODE_UNUSED, 5'd13, SIZE_MAX, 3'd7);
        add_item(MODE_READ_CELL, 5'd0, '0, 3'd0);
        add_item(MODE_READ_CELL, 5'd0, '0, 3'd1);
        add_item(MODE_READ_CELL, 5'd12, '0, 3'd5);
        add_item(MODE_READ_CELL, 5'd13, '0, 3'd6);
        add_item(MODE_READ_CELL, 5'd31, SIZE_MAX, 3'd7);
        add_item(MODE_READ_CELL, 5'd20, '0, 3'd3);
        add_item(MODE_READ_TOTAL, 5'd31, SIZE_MAX, 3'd7);
        add_item(MODE_UNUSED, 5'd0, '0, 3'd0);
        add_item(MODE_READ_TOTAL, 5'd0, '0, 3'd0, 1'b1);
        // Back-to-back record and read of the same cell
        add_item(MODE_RECORD, 5'd13, 32'd120000, 3'd0);
        add_item(MODE_READ_CELL, 5'd13, '0, 3'd4);
        add_item(MODE_READ_CELL, 5'd29, '0, 3'd4);
        add_item(MODE_READ_TOTAL, 5'd0, '0, 3'd0);
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // All limits zero, sender idling; unmapped indexes must be ignored
        send_idle_pct  = 60;
        recv_stall_pct = 0;
        for (int i = REG_EDGE_ONE; i <= REG_EDGE_SIX; i++)
            write_reg(CFG_IDX_W'(i), '0);
        write_reg(REG_UNMAPPED_LO, SIZE_MAX);
        write_reg(REG_UNMAPPED_HI, $urandom);
        end_writes();
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // Unsorted limits, receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        write_reg(REG_EDGE_ONE, $urandom_range(60000, 120000));
        write_reg(REG_EDGE_TWO, $urandom_range(0, 1000));
        write_reg(REG_EDGE_THREE, $urandom_range(1000, 60000));
        write_reg(REG_EDGE_FOUR, $urandom);
        write_reg(REG_EDGE_FIVE, $urandom_range(0, 100));
        write_reg(REG_EDGE_SIX, SIZE_MAX);
        end_writes();
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // All limits at maximum, both sides idling; finish with a full sweep
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        for (int i = REG_EDGE_ONE; i <= REG_EDGE_SIX; i++)
            write_reg(CFG_IDX_W'(i), SIZE_MAX);
        end_writes();
        queue_random(RANDOM_ITEMS);
        for (int r = 0; r < NUM_TYPES; r++)
            for (int b = 0; b < NUM_BUCKETS; b++)
                add_item(MODE_READ_CELL, TYPE_W'(r), '0, COL_W'(b));
        add_item(MODE_READ_TOTAL, 5'd0, '0, 3'd0);
        wait_drained();

        $display("Covered %0d records, %0d cell reads, %0d total reads, %0d ignored items",
                 n_records, n_cell_reads, n_total_reads, n_ignored);
        $display("%0d read values checked over %0d register writes, %0d mismatches",
                 n_checked, n_cfg_writes, mismatches);
        if (mismatches == 0 && read_value_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
